// ===== hw/rtl/i2cm_pkg.sv =====
// Shared types and constants for the I2C master byte engine.
`default_nettype none

package i2cm_pkg;

   localparam logic [2:0] KIND_NONE      = 3'd0;
   localparam logic [2:0] KIND_START     = 3'd1;
   localparam logic [2:0] KIND_STOP      = 3'd2;
   localparam logic [2:0] KIND_WRITE     = 3'd3;
   localparam logic [2:0] KIND_READ_ACK  = 3'd4;
   localparam logic [2:0] KIND_READ_NACK = 3'd5;

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_TICKS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACK_TIMEOUT = 1'b1;

   localparam logic [7:0] PHASE_TICKS_RESET = 8'd5;
   localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd200;
   localparam logic [7:0] COUNT_MAX         = 8'd255;
   localparam logic [3:0] BITS_PER_BYTE     = 4'd8;

   localparam int CMD_QUEUE_DEPTH_DEF = 4;
   localparam int RSP_QUEUE_DEPTH_DEF = 2;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_START,
      CMD_STOP,
      CMD_WRITE,
      CMD_READ_ACK,
      CMD_READ_NACK
   } cmd_code_type;

   typedef struct packed {
      cmd_code_type cmd;
      logic [7:0]   data_byte;
      logic         sda_in;
   } cmd_entry_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_release;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic       ack_ok;
      logic       timed_out;
   } rsp_entry_type;

endpackage

`default_nettype wire

// ===== hw/rtl/i2c_master_byte_engine_unit.sv =====
// Top level of the I2C master byte engine: front end, sequencer and queues.
// A tick beat is registered in the command queue, and its result in the result queue, before it shows.
// Throughput: one tick beat per cycle while the result queue has room, one phase sequencer step each.
// The command queue absorbs short result-side stalls; full rises when it fills.
// Reset is synchronous: queues empty, sequencer idle, both lines released,
// phase_ticks 5 and ack_timeout 200.
`default_nettype none

module i2c_master_byte_engine_unit #(
   parameter int CMD_QUEUE_DEPTH = i2cm_pkg::CMD_QUEUE_DEPTH_DEF,
   parameter int RSP_QUEUE_DEPTH = i2cm_pkg::RSP_QUEUE_DEPTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               push,
   output logic                                    full,
   input  wire logic [2:0]                         req_kind,
   input  wire logic [7:0]                         req_data_byte,
   input  wire logic                               req_sda_in,
   output logic                                    empty,
   input  wire logic                               pop,
   output logic                                    rsp_scl_out,
   output logic                                    rsp_sda_release,
   output logic                                    rsp_busy_res,
   output logic                                    rsp_done_res,
   output logic [7:0]                              rsp_read_data,
   output logic                                    rsp_ack_ok,
   output logic                                    rsp_timed_out,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [i2cm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [7:0]                         csr_wdata
);

   import i2cm_pkg::*;

   logic          cmd_valid;
   logic          cmd_pop;
   cmd_entry_type cmd_entry;
   rsp_entry_type rsp_entry;

   i2cm_front #(
      .DEPTH(CMD_QUEUE_DEPTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (push),
      .req_full     (full),
      .req_kind     (req_kind),
      .req_data_byte(req_data_byte),
      .req_sda_in   (req_sda_in),
      .cmd_pop      (cmd_pop),
      .cmd_valid    (cmd_valid),
      .cmd_entry    (cmd_entry)
   );

   i2cm_back #(
      .DEPTH(RSP_QUEUE_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_valid(cmd_valid),
      .cmd_entry(cmd_entry),
      .cmd_pop  (cmd_pop),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .rsp_pop  (pop),
      .rsp_empty(empty),
      .rsp_entry(rsp_entry)
   );

   assign rsp_scl_out     = rsp_entry.scl_out;
   assign rsp_sda_release = rsp_entry.sda_release;
   assign rsp_busy_res    = rsp_entry.busy_res;
   assign rsp_done_res    = rsp_entry.done_res;
   assign rsp_read_data   = rsp_entry.read_data;
   assign rsp_ack_ok      = rsp_entry.ack_ok;
   assign rsp_timed_out   = rsp_entry.timed_out;

   // A finished command always leaves the sequencer idle.
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      !empty |-> !(rsp_done_res && rsp_busy_res))
      else $error("done and busy shown together");

   // A forced stop after a missing acknowledge never reports an acknowledge.
   a_timeout_no_ack: assert property (@(posedge clock) disable iff (reset)
      !empty |-> !(rsp_timed_out && rsp_ack_ok))
      else $error("timeout and ack shown together");

   // Both queues come out of reset empty.
   a_reset_empty: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> (empty && !full))
      else $error("queues not empty after reset");

endmodule

`default_nettype wire

// ===== hw/rtl/i2cm_fifo.sv =====
// Small first-in first-out queue built as a shift line of registers.
`default_nettype none

module i2cm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rd_data,
   output logic                  full,
   output logic                  empty
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [WIDTH-1:0] entry_in [DEPTH];
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] wr_pos;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = entry_ff[0];
   assign wr_pos  = do_pop ? (count_ff - CNT_W'(1)) : count_ff;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         entry_in[i] = entry_ff[i];
      end
      if (do_pop) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            entry_in[i] = entry_ff[i+1];
         end
      end
      if (do_push) begin
         entry_in[wr_pos[IDX_W-1:0]] = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/i2cm_front.sv =====
// Front end: accepts input beats, decodes the command kind and queues them.
`default_nettype none

module i2cm_front #(
   parameter int DEPTH = i2cm_pkg::CMD_QUEUE_DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_push,
   output logic                       req_full,
   input  wire logic [2:0]            req_kind,
   input  wire logic [7:0]            req_data_byte,
   input  wire logic                  req_sda_in,
   input  wire logic                  cmd_pop,
   output logic                       cmd_valid,
   output i2cm_pkg::cmd_entry_type    cmd_entry
);

   import i2cm_pkg::*;

   cmd_entry_type              new_entry;
   cmd_code_type               code;
   logic [$bits(cmd_entry_type)-1:0] head_bits;
   logic                       cmd_empty;

   always_comb begin
      unique case (req_kind)
         KIND_START:     code = CMD_START;
         KIND_STOP:      code = CMD_STOP;
         KIND_WRITE:     code = CMD_WRITE;
         KIND_READ_ACK:  code = CMD_READ_ACK;
         KIND_READ_NACK: code = CMD_READ_NACK;
         default:        code = CMD_NONE;
      endcase
   end

   assign new_entry.cmd       = code;
   assign new_entry.data_byte = req_data_byte;
   assign new_entry.sda_in    = req_sda_in;

   i2cm_fifo #(
      .WIDTH($bits(cmd_entry_type)),
      .DEPTH(DEPTH)
   ) u_cmd_q (
      .clock  (clock),
      .reset  (reset),
      .push   (req_push),
      .wr_data(new_entry),
      .pop    (cmd_pop),
      .rd_data(head_bits),
      .full   (req_full),
      .empty  (cmd_empty)
   );

   assign cmd_entry = head_bits;
   assign cmd_valid = !cmd_empty;

endmodule

`default_nettype wire

// ===== hw/rtl/i2cm_back.sv =====
// Back end: bus phase sequencer, configuration registers and result queue.
`default_nettype none

module i2cm_back #(
   parameter int DEPTH = i2cm_pkg::RSP_QUEUE_DEPTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               cmd_valid,
   input  wire i2cm_pkg::cmd_entry_type            cmd_entry,
   output logic                                    cmd_pop,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [i2cm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [7:0]                         csr_wdata,
   input  wire logic                               rsp_pop,
   output logic                                    rsp_empty,
   output i2cm_pkg::rsp_entry_type                 rsp_entry
);

   import i2cm_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_S1, ST_S2, ST_S3, ST_S4, ST_P1, ST_P2, ST_WL,
      ST_WH, ST_AL, ST_AW, ST_RL, ST_RH, ST_KL, ST_KH
   } state_type;

   state_type  state_ff,     state_in;
   logic [3:0] bit_count_ff, bit_count_in;
   logic [7:0] shift_ff,     shift_in;
   logic [7:0] tick_ff,      tick_in;
   logic [7:0] wait_ff,      wait_in;
   logic       scl_ff,       scl_in;
   logic       sda_ff,       sda_in;
   logic [7:0] rdata_ff,     rdata_in;
   logic       ack_ok_ff,    ack_ok_in;
   logic       timed_out_ff, timed_out_in;
   logic [7:0] phase_ticks_ff;
   logic [7:0] ack_timeout_ff;

   logic       done_in;
   logic [7:0] tick_inc;
   logic [7:0] wait_inc;
   logic       phase_done;
   logic [3:0] bit_next;
   logic [7:0] rx_shift;
   logic       rsp_full;
   logic       step;
   rsp_entry_type result;
   logic [$bits(rsp_entry_type)-1:0] head_bits;

   assign step      = cmd_valid && !rsp_full;
   assign cmd_pop   = step;
   assign csr_ready = 1'b1;

   assign tick_inc   = (tick_ff != COUNT_MAX) ? tick_ff + 8'd1 : tick_ff;
   assign wait_inc   = (wait_ff != COUNT_MAX) ? wait_ff + 8'd1 : wait_ff;
   assign phase_done = (tick_inc >= phase_ticks_ff);
   assign bit_next   = bit_count_ff + 4'd1;
   assign rx_shift   = {shift_ff[6:0], cmd_entry.sda_in};

   always_comb begin
      state_in     = state_ff;
      bit_count_in = bit_count_ff;
      shift_in     = shift_ff;
      tick_in      = tick_ff;
      wait_in      = wait_ff;
      scl_in       = scl_ff;
      sda_in       = sda_ff;
      rdata_in     = rdata_ff;
      ack_ok_in    = ack_ok_ff;
      timed_out_in = timed_out_ff;
      done_in      = 1'b0;

      unique case (state_ff) inside
         ST_IDLE: begin
            unique case (cmd_entry.cmd) inside
               CMD_START: begin
                  state_in = ST_S1;
                  tick_in  = '0;
                  sda_in   = 1'b1;
               end
               CMD_STOP: begin
                  state_in = ST_P1;
                  tick_in  = '0;
                  scl_in   = 1'b0;
                  sda_in   = 1'b0;
               end
               CMD_WRITE: begin
                  ack_ok_in    = 1'b0;
                  timed_out_in = 1'b0;
                  shift_in     = cmd_entry.data_byte;
                  bit_count_in = '0;
                  state_in     = ST_WL;
                  tick_in      = '0;
                  scl_in       = 1'b0;
                  sda_in       = cmd_entry.data_byte[7];
               end
               CMD_READ_ACK, CMD_READ_NACK: begin
                  shift_in     = '0;
                  bit_count_in = '0;
                  wait_in      = (cmd_entry.cmd == CMD_READ_NACK) ? 8'd1 : 8'd0;
                  state_in     = ST_RL;
                  tick_in      = '0;
                  scl_in       = 1'b0;
                  sda_in       = 1'b1;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_S1, ST_S2, ST_S3, ST_S4, ST_P1, ST_P2, ST_WL, ST_WH, ST_AL,
         ST_RL, ST_RH, ST_KL, ST_KH: begin
            tick_in = tick_inc;
            if (phase_done) begin
               tick_in = '0;
               unique case (state_ff)
                  ST_S1: begin
                     state_in = ST_S2;
                     scl_in   = 1'b1;
                     sda_in   = 1'b1;
                  end
                  ST_S2: begin
                     state_in = ST_S3;
                     scl_in   = 1'b1;
                     sda_in   = 1'b0;
                  end
                  ST_S3: begin
                     state_in = ST_S4;
                     scl_in   = 1'b0;
                     sda_in   = 1'b0;
                  end
                  ST_S4: begin
                     state_in = ST_IDLE;
                     done_in  = 1'b1;
                  end
                  ST_P1: begin
                     state_in = ST_P2;
                     scl_in   = 1'b1;
                     sda_in   = 1'b0;
                  end
                  ST_P2: begin
                     state_in = ST_IDLE;
                     scl_in   = 1'b1;
                     sda_in   = 1'b1;
                     done_in  = 1'b1;
                  end
                  ST_WL: begin
                     state_in = ST_WH;
                     scl_in   = 1'b1;
                  end
                  ST_WH: begin
                     shift_in     = {shift_ff[6:0], 1'b0};
                     bit_count_in = bit_next;
                     scl_in       = 1'b0;
                     if (bit_next >= BITS_PER_BYTE) begin
                        state_in = ST_AL;
                        sda_in   = 1'b1;
                     end else begin
                        state_in = ST_WL;
                        sda_in   = shift_ff[6];
                     end
                  end
                  ST_AL: begin
                     state_in = ST_AW;
                     scl_in   = 1'b1;
                     sda_in   = 1'b1;
                     wait_in  = '0;
                  end
                  ST_RL: begin
                     state_in = ST_RH;
                     scl_in   = 1'b1;
                     sda_in   = 1'b1;
                  end
                  ST_RH: begin
                     shift_in     = rx_shift;
                     bit_count_in = bit_next;
                     scl_in       = 1'b0;
                     if (bit_next >= BITS_PER_BYTE) begin
                        rdata_in = rx_shift;
                        state_in = ST_KL;
                        sda_in   = (wait_ff != '0);
                     end else begin
                        state_in = ST_RL;
                        sda_in   = 1'b1;
                     end
                  end
                  ST_KL: begin
                     state_in = ST_KH;
                     scl_in   = 1'b1;
                  end
                  ST_KH: begin
                     state_in = ST_IDLE;
                     scl_in   = 1'b0;
                     done_in  = 1'b1;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_AW: begin
            if (!cmd_entry.sda_in) begin
               ack_ok_in = 1'b1;
               state_in  = ST_IDLE;
               tick_in   = '0;
               scl_in    = 1'b0;
               sda_in    = 1'b1;
               done_in   = 1'b1;
            end else begin
               wait_in = wait_inc;
               if (wait_inc >= ack_timeout_ff) begin
                  timed_out_in = 1'b1;
                  state_in     = ST_P1;
                  tick_in      = '0;
                  scl_in       = 1'b0;
                  sda_in       = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
            tick_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         bit_count_ff   <= '0;
         shift_ff       <= '0;
         tick_ff        <= '0;
         wait_ff        <= '0;
         scl_ff         <= 1'b1;
         sda_ff         <= 1'b1;
         rdata_ff       <= '0;
         ack_ok_ff      <= 1'b0;
         timed_out_ff   <= 1'b0;
         phase_ticks_ff <= PHASE_TICKS_RESET;
         ack_timeout_ff <= ACK_TIMEOUT_RESET;
      end else begin
         if (step) begin
            state_ff     <= state_in;
            bit_count_ff <= bit_count_in;
            shift_ff     <= shift_in;
            tick_ff      <= tick_in;
            wait_ff      <= wait_in;
            scl_ff       <= scl_in;
            sda_ff       <= sda_in;
            rdata_ff     <= rdata_in;
            ack_ok_ff    <= ack_ok_in;
            timed_out_ff <= timed_out_in;
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_PHASE_TICKS: phase_ticks_ff <= csr_wdata;
               CSR_ACK_TIMEOUT: ack_timeout_ff <= csr_wdata;
               default:         phase_ticks_ff <= phase_ticks_ff;
            endcase
         end
      end
   end

   assign result.scl_out     = scl_in;
   assign result.sda_release = sda_in;
   assign result.busy_res    = (state_in != ST_IDLE);
   assign result.done_res    = done_in;
   assign result.read_data   = rdata_in;
   assign result.ack_ok      = ack_ok_in;
   assign result.timed_out   = timed_out_in;

   i2cm_fifo #(
      .WIDTH($bits(rsp_entry_type)),
      .DEPTH(DEPTH)
   ) u_rsp_q (
      .clock  (clock),
      .reset  (reset),
      .push   (step),
      .wr_data(result),
      .pop    (rsp_pop),
      .rd_data(head_bits),
      .full   (rsp_full),
      .empty  (rsp_empty)
   );

   assign rsp_entry = head_bits;

endmodule

`default_nettype wire

// ===== test/i2c_master_byte_engine_unit_tb.sv =====
// Self-checking testbench for the I2C master byte engine with directed and random tick streams.
`timescale 1ns / 100ps

module i2c_master_byte_engine_unit_tb;

   import i2cm_pkg::*;

   typedef enum logic [3:0] {
      SQ_IDLE,
      SQ_START_1,
      SQ_START_2,
      SQ_START_3,
      SQ_START_4,
      SQ_STOP_1,
      SQ_STOP_2,
      SQ_WR_LOW,
      SQ_WR_HIGH,
      SQ_ACK_LOW,
      SQ_ACK_WAIT,
      SQ_RD_LOW,
      SQ_RD_HIGH,
      SQ_ACKOUT_LOW,
      SQ_ACKOUT_HIGH
   } seq_state_type;

   class bus_tick_scoreboard;
      bit [7:0]      phase_len = PHASE_TICKS_RESET;
      bit [7:0]      ack_limit = ACK_TIMEOUT_RESET;
      seq_state_type st = SQ_IDLE;
      bit [3:0]      nbits;
      bit [7:0]      shreg;
      bit [7:0]      ticks;
      bit [7:0]      waits;
      bit            nack_last;
      bit            scl = 1'b1;
      bit            sda = 1'b1;
      bit [7:0]      rd_byte;
      bit            acked;
      bit            tmo;
      rsp_entry_type pending_status[$];
      int unsigned   mismatches;
      int unsigned   compared;
      int unsigned   ticks_seen;
      int unsigned   cmds_started;
      int unsigned   timeouts;

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [7:0] val);
         if (idx == CSR_PHASE_TICKS) begin
            phase_len = val;
         end else begin
            ack_limit = val;
         end
      endfunction

      function void go(seq_state_type s, bit c, bit d);
         st = s;
         ticks = '0;
         scl = c;
         sda = d;
      endfunction

      function bit phase_over();
         if (ticks != COUNT_MAX) ticks++;
         return ticks >= phase_len;
      endfunction

      function void predict_tick(logic [2:0] kind, logic [7:0] db, logic sda_in);
         rsp_entry_type r;
         bit done;
         done = 1'b0;
         ticks_seen++;
         case (st)
            SQ_IDLE: begin
               case (kind) inside
                  KIND_START: go(SQ_START_1, scl, 1'b1);
                  KIND_STOP: go(SQ_STOP_1, 1'b0, 1'b0);
                  KIND_WRITE: begin
                     acked = 1'b0;
                     tmo = 1'b0;
                     shreg = db;
                     nbits = '0;
                     go(SQ_WR_LOW, 1'b0, db[7]);
                  end
                  KIND_READ_ACK, KIND_READ_NACK: begin
                     shreg = '0;
                     nbits = '0;
                     nack_last = (kind == KIND_READ_NACK);
                     go(SQ_RD_LOW, 1'b0, 1'b1);
                  end
                  default: ;
               endcase
               if (st != SQ_IDLE) cmds_started++;
            end
            SQ_START_1: if (phase_over()) go(SQ_START_2, 1'b1, 1'b1);
            SQ_START_2: if (phase_over()) go(SQ_START_3, 1'b1, 1'b0);
            SQ_START_3: if (phase_over()) go(SQ_START_4, 1'b0, 1'b0);
            SQ_START_4: if (phase_over()) begin
               st = SQ_IDLE;
               ticks = '0;
               done = 1'b1;
            end
            SQ_STOP_1: if (phase_over()) go(SQ_STOP_2, 1'b1, 1'b0);
            SQ_STOP_2: if (phase_over()) begin
               go(SQ_IDLE, 1'b1, 1'b1);
               done = 1'b1;
            end
            SQ_WR_LOW: if (phase_over()) go(SQ_WR_HIGH, 1'b1, sda);
            SQ_WR_HIGH: if (phase_over()) begin
               shreg = shreg << 1;
               nbits++;
               if (nbits >= BITS_PER_BYTE) go(SQ_ACK_LOW, 1'b0, 1'b1);
               else go(SQ_WR_LOW, 1'b0, shreg[7]);
            end
            SQ_ACK_LOW: if (phase_over()) begin
               go(SQ_ACK_WAIT, 1'b1, 1'b1);
               waits = '0;
            end
            SQ_ACK_WAIT: begin
               if (!sda_in) begin
                  acked = 1'b1;
                  go(SQ_IDLE, 1'b0, 1'b1);
                  done = 1'b1;
               end else begin
                  if (waits != COUNT_MAX) waits++;
                  if (waits >= ack_limit) begin
                     tmo = 1'b1;
                     timeouts++;
                     go(SQ_STOP_1, 1'b0, 1'b0);
                  end
               end
            end
            SQ_RD_LOW: if (phase_over()) go(SQ_RD_HIGH, 1'b1, 1'b1);
            SQ_RD_HIGH: if (phase_over()) begin
               shreg = {shreg[6:0], sda_in};
               nbits++;
               if (nbits >= BITS_PER_BYTE) begin
                  rd_byte = shreg;
                  go(SQ_ACKOUT_LOW, 1'b0, nack_last);
               end else begin
                  go(SQ_RD_LOW, 1'b0, 1'b1);
               end
            end
            SQ_ACKOUT_LOW: if (phase_over()) go(SQ_ACKOUT_HIGH, 1'b1, sda);
            SQ_ACKOUT_HIGH: if (phase_over()) begin
               go(SQ_IDLE, 1'b0, sda);
               done = 1'b1;
            end
            default: begin
               st = SQ_IDLE;
               ticks = '0;
            end
         endcase
         r.scl_out = scl;
         r.sda_release = sda;
         r.busy_res = (st != SQ_IDLE);
         r.done_res = done;
         r.read_data = rd_byte;
         r.ack_ok = acked;
         r.timed_out = tmo;
         pending_status.push_back(r);
      endfunction

      function void cmp(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_status(rsp_entry_type got);
         rsp_entry_type want;
         if (pending_status.size() == 0) begin
            $error("Result beat arrived while no result was expected.");
            mismatches++;
            return;
         end
         want = pending_status.pop_front();
         compared++;
         cmp("scl_out", want.scl_out, got.scl_out);
         cmp("sda_release", want.sda_release, got.sda_release);
         cmp("busy_res", want.busy_res, got.busy_res);
         cmp("done_res", want.done_res, got.done_res);
         cmp("read_data", want.read_data, got.read_data);
         cmp("ack_ok", want.ack_ok, got.ack_ok);
         cmp("timed_out", want.timed_out, got.timed_out);
      endfunction
   endclass

   localparam logic [2:0] KIND_SPARE_LO = 3'd6;
   localparam logic [2:0] KIND_SPARE_HI = 3'd7;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   push = 1'b0;
   logic                   full;
   logic [2:0]             req_kind = KIND_NONE;
   logic [7:0]             req_data_byte = '0;
   logic                   req_sda_in = 1'b1;
   logic                   empty;
   logic                   pop = 1'b0;
   logic                   rsp_scl_out;
   logic                   rsp_sda_release;
   logic                   rsp_busy_res;
   logic                   rsp_done_res;
   logic [7:0]             rsp_read_data;
   logic                   rsp_ack_ok;
   logic                   rsp_timed_out;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_PHASE_TICKS;
   logic [7:0]             csr_wdata = '0;

   bus_tick_scoreboard sb = new();

   int unsigned tx_idle_pct = 21;
   int unsigned rx_idle_pct = 66;
   int unsigned rx_hold = 0;
   int unsigned ack_pct = 100;
   int unsigned ones_pct = 50;

   i2c_master_byte_engine_unit u_dut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_kind        (req_kind),
      .req_data_byte   (req_data_byte),
      .req_sda_in      (req_sda_in),
      .empty           (empty),
      .pop             (pop),
      .rsp_scl_out     (rsp_scl_out),
      .rsp_sda_release (rsp_sda_release),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_done_res    (rsp_done_res),
      .rsp_read_data   (rsp_read_data),
      .rsp_ack_ok      (rsp_ack_ok),
      .rsp_timed_out   (rsp_timed_out),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // The slave drives SDA: an ACK with some chance per tick in the ACK wait, data otherwise.
   function automatic logic bus_sda();
      if (sb.st == SQ_ACK_WAIT) return ($urandom_range(99) < ack_pct) ? 1'b0 : 1'b1;
      return ($urandom_range(99) < ones_pct) ? 1'b1 : 1'b0;
   endfunction

   task automatic send_tick(input logic [2:0] k, input logic [7:0] d, input logic s);
      logic sent;
      sent = 1'b0;
      while (!sent) begin
         @(negedge clock);
         if ($urandom_range(99) < tx_idle_pct) begin
            push = 1'b0;
         end else begin
            push = 1'b1;
            req_kind = k;
            req_data_byte = d;
            req_sda_in = s;
         end
         @(posedge clock);
         if (push && !full) begin
            sb.predict_tick(k, d, s);
            sent = 1'b1;
         end
      end
   endtask

   task automatic run_cmd(input logic [2:0] k, input logic [7:0] d);
      send_tick(k, d, bus_sda());
      while (sb.st != SQ_IDLE) send_tick(KIND_NONE, 8'($urandom), bus_sda());
   endtask

   task automatic settle();
      @(negedge clock);
      push = 1'b0;
      while (sb.pending_status.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_regs(input logic [7:0] phase_val, input logic [7:0] tmo_val);
      settle();
      for (int i = 0; i < 2; i++) begin
         @(negedge clock);
         csr_valid = 1'b1;
         csr_index = (i == 0) ? CSR_PHASE_TICKS : CSR_ACK_TIMEOUT;
         csr_wdata = (i == 0) ? phase_val : tmo_val;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         sb.write_reg(csr_index, csr_wdata);
      end
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic random_ticks(input int unsigned count);
      int unsigned stop_at;
      int unsigned r;
      logic [2:0]  k;
      stop_at = sb.ticks_seen + count;
      while (sb.ticks_seen < stop_at) begin
         r = $urandom_range(99);
         if (sb.st == SQ_IDLE) begin
            if (r < 10) k = KIND_NONE;
            else if (r < 14) k = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
            else k = 3'($urandom_range(KIND_START, KIND_READ_NACK));
            r = $urandom_range(99);
            ack_pct = (r < 25) ? 0 : (r < 60) ? 20 : 100;
            r = $urandom_range(99);
            ones_pct = (r < 10) ? 0 : (r < 20) ? 100 : 50;
         end else begin
            k = (r < 8) ? 3'($urandom_range(KIND_START, KIND_SPARE_HI)) : KIND_NONE;
         end
         send_tick(k, 8'($urandom), bus_sda());
      end
   endtask

   initial begin
      rsp_entry_type got;
      forever begin
         @(negedge clock);
         if (rx_hold != 0) begin
            pop = 1'b0;
            rx_hold--;
         end else begin
            pop = ($urandom_range(99) >= rx_idle_pct);
         end
         @(posedge clock);
         if (pop && !empty && !reset) begin
            got.scl_out = rsp_scl_out;
            got.sda_release = rsp_sda_release;
            got.busy_res = rsp_busy_res;
            got.done_res = rsp_done_res;
            got.read_data = rsp_read_data;
            got.ack_ok = rsp_ack_ok;
            got.timed_out = rsp_timed_out;
            sb.check_status(got);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      run_cmd(KIND_START, 8'h00);
      write_regs(8'd1, 8'd4);
      run_cmd(KIND_START, 8'h11);
      ack_pct = 100;
      run_cmd(KIND_WRITE, 8'hFF);
      ack_pct = 0;
      run_cmd(KIND_WRITE, 8'h00);
      ack_pct = 30;
      run_cmd(KIND_WRITE, 8'hA5);
      ones_pct = 100;
      run_cmd(KIND_READ_ACK, 8'h00);
      ones_pct = 0;
      run_cmd(KIND_READ_NACK, 8'hFF);
      ones_pct = 50;
      run_cmd(KIND_READ_NACK, 8'h5A);
      run_cmd(KIND_STOP, 8'h00);
      send_tick(KIND_SPARE_LO, 8'hFF, 1'b0);
      send_tick(KIND_SPARE_HI, 8'h00, 1'b1);
      send_tick(KIND_NONE, 8'h81, 1'b0);
      // A read offered while the write is still running must be ignored.
      ack_pct = 100;
      send_tick(KIND_WRITE, 8'h3C, 1'b1);
      run_cmd(KIND_READ_ACK, 8'hC3);

      write_regs(8'd0, 8'd0);
      ack_pct = 0;
      run_cmd(KIND_WRITE, 8'h5A);
      run_cmd(KIND_READ_NACK, 8'h00);
      run_cmd(KIND_START, 8'h00);
      write_regs(8'd255, 8'd255);
      run_cmd(KIND_STOP, 8'h00);
      write_regs(8'd1, 8'd255);
      run_cmd(KIND_WRITE, 8'h96);

      write_regs(8'($urandom_range(1, 3)), 8'($urandom_range(2, 12)));
      random_ticks(100);
      settle();
      random_ticks(100);

      write_regs(8'($urandom_range(1, 3)), 8'($urandom_range(2, 12)));
      tx_idle_pct = 66;
      rx_idle_pct = 21;
      random_ticks(100);

      write_regs(8'($urandom_range(1, 3)), 8'($urandom_range(1, 12)));
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      rx_hold = 80;
      random_ticks(100);

      settle();
      $display("Summary: %0d ticks driven, %0d commands started, %0d ACK timeouts forced.",
               sb.ticks_seen, sb.cmds_started, sb.timeouts);
      $display("Summary: %0d result beats compared, %0d field mismatches.",
               sb.compared, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
